// ===== hw/rtl/timeout_deadline_queue_core_macros.svh =====
// Assertion macros for the timer queue core.
// Used by the top level only; no other dependency.
`ifndef TIMEOUT_DEADLINE_QUEUE_CORE_MACROS_SVH
`define TIMEOUT_DEADLINE_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TDQ_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");
`define TDQ_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed: label");
`else
`define TDQ_ASSERT_IMPL(label, clk, rst, prop)
`define TDQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/tdq_pkg.sv =====
// Shared types and constants of the timer queue core.
// No dependencies.
package tdq_pkg;
   localparam logic [1:0] ACT_SCHEDULE = 2'd0;
   localparam logic [1:0] ACT_CANCEL   = 2'd1;
   localparam logic [1:0] ACT_PROCESS  = 2'd2;
   localparam logic [1:0] ACT_QUERY    = 2'd3;

   localparam logic [2:0] KIND_SCHEDULED = 3'd0;
   localparam logic [2:0] KIND_CANCELLED = 3'd1;
   localparam logic [2:0] KIND_EXPIRED   = 3'd2;
   localparam logic [2:0] KIND_WAIT      = 3'd3;
   localparam logic [2:0] KIND_NONE      = 3'd4;

   localparam logic [31:0] EMPTY_WAIT_RESET = 32'd300000;
   localparam int MAX_RESULTS = 16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT, ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture input item
      logic scan_start; // restart the slot sweep
      logic scan_step;  // advance sweep one slot
      logic commit;     // apply action result to store
      logic emit;       // drive one result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic expire_hit;  // process: earliest entry is due
      logic emit_last;   // process: emitted entry ends the item
   } sts_type;
endpackage

// ===== hw/rtl/tdq_ctrl.sv =====
// Controller state machine of the timer queue core.
// Depends on tdq_pkg.
module tdq_ctrl import tdq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      busy_dp,
   input  sts_type   sts,
   output cmd_type   cmd,
   output logic      busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE) || busy_dp;
      case (state_ff)
         ST_IDLE: begin
            // take an item only while no result is still on the ports
            if (start && !busy_dp) begin
               cmd.load = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.commit = 1'b1;
            cmd.emit = 1'b1;
            if (sts.expire_hit && !sts.emit_last) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/tdq_datapath.sv =====
// Slot store, sequential sweep and result formatting of the timer queue.
// Depends on tdq_pkg.
module tdq_datapath import tdq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_now,
   input  logic [30:0] req_timeout_ticks,
   input  logic [15:0] req_user_tag,
   input  logic [31:0] req_cancel_id,
   input  logic        csr_we,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_entry_id,
   output logic [15:0] rsp_expired_tag,
   output logic signed [48:0] rsp_wait_ticks,
   output logic        rsp_became_earliest,
   output logic        rsp_found,
   output logic        rsp_full_error,
   output logic        rsp_last
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(MAX_RESULTS + 1);

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [47:0] dl_ff  [CAPACITY];
   logic [31:0] id_ff  [CAPACITY];
   logic [15:0] tag_ff [CAPACITY];
   logic [31:0] next_id_ff;
   logic [31:0] empty_wait_ff;

   logic [1:0]  act_ff;
   logic [47:0] now_ff;
   logic [47:0] newdl_ff;
   logic [15:0] tag_in_ff;
   logic [31:0] cid_ff;

   logic [CW-1:0] scan_ff;
   logic          best_v_ff;
   logic [IW-1:0] best_ff;
   logic          sec_v_ff;
   logic [IW-1:0] sec_ff;
   logic          free_v_ff;
   logic [IW-1:0] free_ff;
   logic          hit_v_ff;
   logic [IW-1:0] hit_ff;
   logic [RW-1:0] nres_ff;

   logic [IW-1:0] si;
   logic [48:0]   dl_sum;
   logic          due;
   logic          next_due;
   logic          nb_lt;
   logic          lt_best;
   logic          lt_sec;

   logic [2:0]  rsp_kind_in;
   logic [31:0] rsp_entry_id_in;
   logic [15:0] rsp_expired_tag_in;
   logic signed [48:0] rsp_wait_ticks_in;
   logic        rsp_became_earliest_in;
   logic        rsp_found_in;
   logic        rsp_full_error_in;
   logic        rsp_last_in;

   assign si = scan_ff[IW-1:0];
   assign dl_sum = {1'b0, req_now} + {18'd0, req_timeout_ticks};
   assign due = best_v_ff && (dl_ff[best_ff] <= now_ff);
   // runner-up is due too: another expired entry follows this one
   assign next_due = sec_v_ff && (dl_ff[sec_ff] <= now_ff);
   // new entry orders before current best: deadline, then id (ids wrap)
   assign nb_lt = (newdl_ff < dl_ff[best_ff]) ||
                  (newdl_ff == dl_ff[best_ff] && next_id_ff < id_ff[best_ff]);
   assign lt_best = (dl_ff[si] < dl_ff[best_ff]) ||
                    (dl_ff[si] == dl_ff[best_ff] && id_ff[si] < id_ff[best_ff]);
   assign lt_sec = (dl_ff[si] < dl_ff[sec_ff]) ||
                   (dl_ff[si] == dl_ff[sec_ff] && id_ff[si] < id_ff[sec_ff]);

   assign sts.scan_done = (scan_ff == CW'(CAPACITY - 1));
   assign sts.expire_hit = (act_ff == ACT_PROCESS) && due;
   assign sts.emit_last = (nres_ff == RW'(MAX_RESULTS - 1)) || !next_due;

   always_ff @(posedge clock) begin
      if (reset) empty_wait_ff <= EMPTY_WAIT_RESET;
      else if (csr_we) empty_wait_ff <= csr_data;
   end

   // sweep: find earliest and runner-up, lowest free, lowest id match
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         now_ff <= req_now;
         newdl_ff <= dl_sum[48] ? 48'hFFFF_FFFF_FFFF : dl_sum[47:0];
         tag_in_ff <= req_user_tag;
         cid_ff <= req_cancel_id;
         nres_ff <= '0;
      end else if (cmd.emit) begin
         nres_ff <= nres_ff + RW'(1);
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
         best_v_ff <= 1'b0; sec_v_ff <= 1'b0; free_v_ff <= 1'b0; hit_v_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CW'(1);
         if (valid_ff[si]) begin
            if (!best_v_ff || lt_best) begin
               best_v_ff <= 1'b1; best_ff <= si;
               sec_v_ff <= best_v_ff; sec_ff <= best_ff;
            end else if (!sec_v_ff || lt_sec) begin
               sec_v_ff <= 1'b1; sec_ff <= si;
            end
            if (!hit_v_ff && id_ff[si] == cid_ff) begin
               hit_v_ff <= 1'b1; hit_ff <= si;
            end
         end else if (!free_v_ff) begin
            free_v_ff <= 1'b1; free_ff <= si;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         case (act_ff)
            ACT_SCHEDULE: if (free_v_ff) valid_in[free_ff] = 1'b1;
            ACT_CANCEL:   if (hit_v_ff) valid_in[hit_ff] = 1'b0;
            ACT_PROCESS:  if (due) valid_in[best_ff] = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         next_id_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.commit && act_ff == ACT_SCHEDULE && free_v_ff)
            next_id_ff <= next_id_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && act_ff == ACT_SCHEDULE && free_v_ff) begin
         dl_ff[free_ff] <= newdl_ff;
         id_ff[free_ff] <= next_id_ff;
         tag_ff[free_ff] <= tag_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.emit;
   end

   always_comb begin
      rsp_kind_in = KIND_WAIT;
      rsp_entry_id_in = '0;
      rsp_expired_tag_in = '0;
      rsp_wait_ticks_in = '0;
      rsp_became_earliest_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_full_error_in = 1'b0;
      rsp_last_in = 1'b1;
      case (act_ff)
         ACT_SCHEDULE: begin
            rsp_kind_in = KIND_SCHEDULED;
            if (free_v_ff) begin
               rsp_entry_id_in = next_id_ff;
               rsp_became_earliest_in = !best_v_ff || nb_lt;
            end else begin
               rsp_full_error_in = 1'b1;
            end
         end
         ACT_CANCEL: begin
            rsp_kind_in = KIND_CANCELLED;
            rsp_entry_id_in = cid_ff;
            rsp_found_in = hit_v_ff;
         end
         ACT_PROCESS: begin
            if (due) begin
               rsp_kind_in = KIND_EXPIRED;
               rsp_entry_id_in = id_ff[best_ff];
               rsp_expired_tag_in = tag_ff[best_ff];
               rsp_last_in = sts.emit_last;
            end else begin
               rsp_kind_in = KIND_NONE;
            end
         end
         default: begin
            rsp_kind_in = KIND_WAIT;
            rsp_wait_ticks_in = best_v_ff ?
               ({1'b0, dl_ff[best_ff]} - {1'b0, now_ff}) :
               {17'd0, empty_wait_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind <= rsp_kind_in;
         rsp_entry_id <= rsp_entry_id_in;
         rsp_expired_tag <= rsp_expired_tag_in;
         rsp_wait_ticks <= rsp_wait_ticks_in;
         rsp_became_earliest <= rsp_became_earliest_in;
         rsp_found <= rsp_found_in;
         rsp_full_error <= rsp_full_error_in;
         rsp_last <= rsp_last_in;
      end
   end
endmodule

// ===== hw/rtl/timeout_deadline_queue_core.sv =====
// Top level of the deadline-ordered timer queue core.
// Depends on tdq_pkg, tdq_ctrl, tdq_datapath and the assertion macro header.
//
// Each item sweeps all CAPACITY slots one per cycle, then commits and registers
// one result; busy stays high through the sweep and while that result is on
// the ports, so a new item is taken only once the result has gone. A process
// item repeats the sweep and commit per expired entry, up to 16 results, one
// expired result per sweep; an item with nothing due gives one result. Results
// come out on the rsp_ ports for one cycle with rsp_valid high; the receiver
// cannot stall, so each must be taken on the spot. A process item ends on the
// result with rsp_last high; the sweep also tracks the runner-up entry, so the
// last expired entry is known when it is sent. Expired entries come out
// earliest deadline first, ties by id.
`include "timeout_deadline_queue_core_macros.svh"
module timeout_deadline_queue_core import tdq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_now,
   input  logic [30:0] req_timeout_ticks,
   input  logic [15:0] req_user_tag,
   input  logic [31:0] req_cancel_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_entry_id,
   output logic [15:0] rsp_expired_tag,
   output logic signed [48:0] rsp_wait_ticks,
   output logic        rsp_became_earliest,
   output logic        rsp_found,
   output logic        rsp_full_error,
   output logic        rsp_last
);
   cmd_type cmd;
   sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   tdq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy_dp(rsp_valid),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   tdq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_action(req_action), .req_now(req_now),
      .req_timeout_ticks(req_timeout_ticks), .req_user_tag(req_user_tag),
      .req_cancel_id(req_cancel_id),
      .csr_we(csr_valid && csr_ready), .csr_data(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_entry_id(rsp_entry_id),
      .rsp_expired_tag(rsp_expired_tag), .rsp_wait_ticks(rsp_wait_ticks),
      .rsp_became_earliest(rsp_became_earliest), .rsp_found(rsp_found),
      .rsp_full_error(rsp_full_error), .rsp_last(rsp_last)
   );

   // a new item never starts while a result is on the ports
   `TDQ_ASSERT_IMPL(a_busy_on_rsp, clock, reset, rsp_valid |-> busy)
   // an accepted item keeps the block busy in the next cycle
   `TDQ_ASSERT_IMPL(a_start_busy, clock, reset, (start && !busy) |=> busy)
   // full error only on a schedule result and never with an id
   `TDQ_ASSERT_IMPL(a_full_kind, clock, reset,
      (rsp_valid && rsp_full_error) |-> (rsp_kind == KIND_SCHEDULED && rsp_entry_id == 32'd0))
endmodule
